// ----- hdl/oahi_pkg.sv -----
// Package for the open-addressing hash insert core: field widths, register
// indexes, command codes, transfer payload structs and the controller states.
// No dependencies; used by every other file of the block.
package oahi_pkg;

    // Field and register widths.
    localparam int KEY_BITS      = 31;
    localparam int SIZE_W        = 15;
    localparam int SP_W          = 14;
    localparam int SLOT_W        = 14;
    localparam int PROBE_W       = 15;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 15;
    localparam int MAX_SLOTS_DEF = 16384;

    // Register reset values.
    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST   = 15'd16381;
    localparam logic              PROBE_MODE_RST   = 1'b1;
    localparam logic [SP_W-1:0]   SECOND_PRIME_RST = 14'd16333;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROBE_MODE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_PRIME = 2'd2;

    // Command and probe mode codes.
    localparam logic CMD_INSERT  = 1'b0;
    localparam logic CMD_CLEAR   = 1'b1;
    localparam logic MODE_LINEAR = 1'b0;
    localparam logic MODE_DOUBLE = 1'b1;

    // Input transfer payload.
    typedef struct packed {
        logic                cmd;
        logic [KEY_BITS-1:0] key;
    } in_t;

    // Result transfer payload.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [PROBE_W-1:0] probes;
        logic               already_present;
        logic               table_full;
    } out_t;

    // Request to the shared remainder unit.
    typedef struct packed {
        logic                start;
        logic [KEY_BITS-1:0] dividend;
        logic [SIZE_W-1:0]   divisor;
    } div_req_t;

    // Response from the shared remainder unit.
    typedef struct packed {
        logic              done;
        logic [SIZE_W-1:0] remainder;
    } div_rsp_t;

    // Controller states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_HOME,
        ST_DIV_SEC,
        ST_DIV_STEP,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

endpackage

// ----- hdl/open_address_hash_insert_core.sv -----
// Open-addressing hash insert core with linear or double-hashing probe steps.
// Insert: the home slot is a remainder from the shared bit-serial unit; double
// hashing adds a secondary-hash remainder and, when the step needs reducing, a
// step remainder; then each probe is one slot RAM read. Clear sweeps every slot.
// After reset the slot RAM is swept before the first input transfer;
// configuration is always taken.
module open_address_hash_insert_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  oahi_pkg::in_t                     s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output oahi_pkg::out_t                    m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [oahi_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [oahi_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int MAX_SLOTS = oahi_pkg::MAX_SLOTS_DEF;
    localparam int IDX_W  = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int WORD_W = oahi_pkg::KEY_BITS + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SLOTS - 1);

    // Configuration registers.
    logic [oahi_pkg::SIZE_W-1:0] table_size_reg;
    logic                        probe_mode_reg;
    logic [oahi_pkg::SP_W-1:0]   second_prime_reg;

    // Controller registers.
    oahi_pkg::state_t              state_reg, state_next;
    logic [oahi_pkg::KEY_BITS-1:0] key_reg, key_next;
    logic [IDX_W-1:0]              idx_reg, idx_next;
    logic [IDX_W-1:0]              home_reg, home_next;
    logic [IDX_W-1:0]              step_reg, step_next;
    logic [oahi_pkg::PROBE_W-1:0]  n_reg, n_next;
    logic [IDX_W-1:0]              clr_cnt_reg, clr_cnt_next;
    logic                          clr_reply_reg, clr_reply_next;
    oahi_pkg::out_t                res_reg, res_next;
    logic                          m_valid_reg, m_valid_next;
    oahi_pkg::out_t                m_data_reg, m_data_next;

    // Slot RAM: used flag above the stored key.
    logic [WORD_W-1:0] slot_mem [MAX_SLOTS];
    logic [WORD_W-1:0] rdata_reg;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;

    // Remainder unit link.
    oahi_pkg::div_req_t div_req;
    oahi_pkg::div_rsp_t div_rsp;

    // Derived values.
    logic [oahi_pkg::SIZE_W-1:0] eff_size;
    logic [IDX_W:0]              size_ext;
    logic [oahi_pkg::SP_W-1:0]   sp_eff;
    logic [oahi_pkg::SP_W-1:0]   step0;
    logic [IDX_W:0]              step_sum;
    logic [IDX_W:0]              step_wrap;
    logic [IDX_W-1:0]            idx_adv;
    logic                        rd_used;
    logic [oahi_pkg::KEY_BITS-1:0] rd_key;

    // Configuration writes; an index beyond the list is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_size_reg   <= oahi_pkg::TABLE_SIZE_RST;
            probe_mode_reg   <= oahi_pkg::PROBE_MODE_RST;
            second_prime_reg <= oahi_pkg::SECOND_PRIME_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                oahi_pkg::CFG_TABLE_SIZE: begin
                    table_size_reg <= cfg_data[oahi_pkg::SIZE_W-1:0];
                end
                oahi_pkg::CFG_PROBE_MODE: begin
                    probe_mode_reg <= cfg_data[0];
                end
                oahi_pkg::CFG_SECOND_PRIME: begin
                    second_prime_reg <= cfg_data[oahi_pkg::SP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Effective table size: clamped to the RAM depth, zero acts as one.
    always_comb begin
        priority if (32'(table_size_reg) > 32'(MAX_SLOTS)) begin
            eff_size = oahi_pkg::SIZE_W'(MAX_SLOTS);
        end else if (table_size_reg == '0) begin
            eff_size = oahi_pkg::SIZE_W'(1);
        end else begin
            eff_size = table_size_reg;
        end
    end

    assign size_ext = (IDX_W + 1)'(eff_size);
    assign sp_eff   = (second_prime_reg == '0) ? oahi_pkg::SP_W'(1) : second_prime_reg;
    assign step0    = sp_eff - div_rsp.remainder[oahi_pkg::SP_W-1:0];

    // Next probe slot; index and step both lie below the size.
    assign step_sum  = {1'b0, idx_reg} + {1'b0, step_reg};
    assign step_wrap = step_sum - size_ext;
    assign idx_adv   = (step_sum >= size_ext) ? step_wrap[IDX_W-1:0] : step_sum[IDX_W-1:0];

    assign rd_used = rdata_reg[oahi_pkg::KEY_BITS];
    assign rd_key  = rdata_reg[oahi_pkg::KEY_BITS-1:0];

    // Shared remainder unit for home slot, secondary hash and step reduction.
    oahi_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Controller: next state, RAM accesses and result assembly.
    always_comb begin
        state_next     = state_reg;
        key_next       = key_reg;
        idx_next       = idx_reg;
        home_next      = home_reg;
        step_next      = step_reg;
        n_next         = n_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_reply_next = clr_reply_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        div_req        = '0;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = {1'b1, key_reg};
        mem_raddr      = idx_reg;

        unique case (state_reg)
            oahi_pkg::ST_CLEAR: begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == LAST_IDX) begin
                    clr_cnt_next = '0;
                    if (clr_reply_reg) begin
                        res_next   = '0;
                        state_next = oahi_pkg::ST_DONE;
                    end else begin
                        state_next = oahi_pkg::ST_IDLE;
                    end
                end
            end
            oahi_pkg::ST_IDLE: begin
                if (s_valid) begin
                    key_next = s_data.key;
                    if (s_data.cmd == oahi_pkg::CMD_CLEAR) begin
                        clr_reply_next = 1'b1;
                        clr_cnt_next   = '0;
                        state_next     = oahi_pkg::ST_CLEAR;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = s_data.key;
                        div_req.divisor  = eff_size;
                        state_next       = oahi_pkg::ST_DIV_HOME;
                    end
                end
            end
            oahi_pkg::ST_DIV_HOME: begin
                if (div_rsp.done) begin
                    home_next = IDX_W'(div_rsp.remainder);
                    idx_next  = IDX_W'(div_rsp.remainder);
                    if (probe_mode_reg == oahi_pkg::MODE_LINEAR) begin
                        step_next  = (eff_size == oahi_pkg::SIZE_W'(1)) ? '0 : IDX_W'(1);
                        state_next = oahi_pkg::ST_READ;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = key_reg;
                        div_req.divisor  = oahi_pkg::SIZE_W'(sp_eff);
                        state_next       = oahi_pkg::ST_DIV_SEC;
                    end
                end
            end
            oahi_pkg::ST_DIV_SEC: begin
                if (div_rsp.done) begin
                    if ({1'b0, step0} < eff_size) begin
                        step_next  = IDX_W'(step0);
                        state_next = oahi_pkg::ST_READ;
                    end else begin
                        div_req.start    = 1'b1;
                        div_req.dividend = oahi_pkg::KEY_BITS'(step0);
                        div_req.divisor  = eff_size;
                        state_next       = oahi_pkg::ST_DIV_STEP;
                    end
                end
            end
            oahi_pkg::ST_DIV_STEP: begin
                if (div_rsp.done) begin
                    step_next  = IDX_W'(div_rsp.remainder);
                    state_next = oahi_pkg::ST_READ;
                end
            end
            oahi_pkg::ST_READ: begin
                mem_raddr  = idx_reg;
                n_next     = oahi_pkg::PROBE_W'(1);
                state_next = oahi_pkg::ST_CHECK;
            end
            oahi_pkg::ST_CHECK: begin
                // Empty slot stores the key; a matching key ends the walk too.
                priority if (!rd_used) begin
                    mem_we                   = 1'b1;
                    mem_waddr                = idx_reg;
                    res_next.slot            = oahi_pkg::SLOT_W'(idx_reg);
                    res_next.probes          = n_reg;
                    res_next.already_present = 1'b0;
                    res_next.table_full      = 1'b0;
                    state_next               = oahi_pkg::ST_DONE;
                end else if (rd_key == key_reg) begin
                    res_next.slot            = oahi_pkg::SLOT_W'(idx_reg);
                    res_next.probes          = n_reg;
                    res_next.already_present = 1'b1;
                    res_next.table_full      = 1'b0;
                    state_next               = oahi_pkg::ST_DONE;
                end else if (n_reg == eff_size) begin
                    res_next.slot            = oahi_pkg::SLOT_W'(home_reg);
                    res_next.probes          = eff_size;
                    res_next.already_present = 1'b0;
                    res_next.table_full      = 1'b1;
                    state_next               = oahi_pkg::ST_DONE;
                end else begin
                    idx_next  = idx_adv;
                    n_next    = n_reg + oahi_pkg::PROBE_W'(1);
                    mem_raddr = idx_adv;
                end
            end
            oahi_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = oahi_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Controller and output registers; reset starts the clearing sweep.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= oahi_pkg::ST_CLEAR;
            clr_cnt_reg   <= '0;
            clr_reply_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_reply_reg <= clr_reply_next;
            m_valid_reg   <= m_valid_next;
        end
        key_reg    <= key_next;
        idx_reg    <= idx_next;
        home_reg   <= home_next;
        step_reg   <= step_next;
        n_reg      <= n_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // Slot RAM with one write port and a registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= slot_mem[mem_raddr];
    end

    assign s_ready = (state_reg == oahi_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- hdl/oahi_mod_unit.sv -----
// Bit-serial remainder unit: dividend mod divisor, one dividend bit a cycle.
// Depends on oahi_pkg for widths and the request and response structs.
module oahi_mod_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  oahi_pkg::div_req_t  req,
    output oahi_pkg::div_rsp_t  rsp
);

    localparam int CNT_W = $clog2(oahi_pkg::KEY_BITS);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(oahi_pkg::KEY_BITS - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [oahi_pkg::KEY_BITS-1:0] dvd_reg, dvd_next;
    logic [oahi_pkg::SIZE_W-1:0]   dsr_reg, dsr_next;
    logic [oahi_pkg::SIZE_W-1:0]   rem_reg, rem_next;

    logic [oahi_pkg::SIZE_W:0]     trial;
    logic [oahi_pkg::SIZE_W:0]     diff;
    logic                          fits;

    // One restoring step: bring in the next dividend bit and subtract if it fits.
    assign trial = {rem_reg, dvd_reg[oahi_pkg::KEY_BITS-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    // Sequencing of a request and its steps.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (busy_reg) begin
            rem_next = fits ? diff[oahi_pkg::SIZE_W-1:0] : trial[oahi_pkg::SIZE_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_CNT) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
        end
    end

    // Control state is reset; the datapath registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.remainder = rem_reg;

endmodule
